FILE: hw/rtl/least_squares_line_fit_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line fit block
// Implication and exclusion checks, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_LINE_FIT_TOP_ASSERT_SVH
`define LEAST_SQUARES_LINE_FIT_TOP_ASSERT_SVH

`define LSLF_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define LSLF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/lslf_pkg.sv
// ----------------------------------------------------------------------------
// lslf_pkg
// Shared widths, limits and the queue entry tag of the line fit block.
// ----------------------------------------------------------------------------
package lslf_pkg;

  localparam int VALUE_W    = 32;
  localparam int RESULT_W   = 48;
  localparam int POINTS_W   = 7;
  localparam int FRAC_SHIFT = 16;

  localparam logic [RESULT_W-1:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [RESULT_W-1:0] SAT_NEG = 48'h8000_0000_0000;

  typedef struct packed {
    logic incl;
    logic last;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

endpackage

FILE: hw/rtl/lslf_front.sv
// ----------------------------------------------------------------------------
// lslf_front
// Accepts points, marks each as kept or dropped against the point limit.
// ----------------------------------------------------------------------------
module lslf_front #(
  parameter int MAX_POINTS = 64,
  parameter int CODE_BITS  = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [CODE_BITS-1:0]                  sample_code,
  input  logic signed [lslf_pkg::VALUE_W-1:0]   true_value,
  input  logic                                  last_point,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [lslf_pkg::TAG_W+lslf_pkg::VALUE_W+CODE_BITS-1:0] push_data
);

  localparam int NB = $clog2(MAX_POINTS + 1);

  logic [NB-1:0]   count;
  lslf_pkg::tag_t  tag;

  assign tag.incl   = count < NB'(MAX_POINTS);
  assign tag.last   = last_point;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_data  = {tag, true_value, sample_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_valid && push_ready) begin
      if (last_point) begin
        count <= '0;
      end else if (tag.incl) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/lslf_fifo.sv
// ----------------------------------------------------------------------------
// lslf_fifo
// Two-entry queue between the front and the fit engine.
// ----------------------------------------------------------------------------
module lslf_fifo #(
  parameter int W = 46
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;
  logic         push;
  logic         pop;

  assign push_ready = fill != 2'd2;
  assign pop_valid  = fill != 2'd0;
  assign pop_data   = mem[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hw/rtl/lslf_back.sv
// ----------------------------------------------------------------------------
// lslf_back
// Keeps the running sums and computes the fit with a serial multiplier and
// a restoring divider.
// ----------------------------------------------------------------------------
module lslf_back #(
  parameter int MAX_POINTS = 64,
  parameter int CODE_BITS  = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  logic [lslf_pkg::TAG_W+lslf_pkg::VALUE_W+CODE_BITS-1:0] pop_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lslf_pkg::RESULT_W-1:0]  intercept,
  output logic signed [lslf_pkg::RESULT_W-1:0]  slope,
  output logic                                  degenerate,
  output logic                                  overflowed,
  output logic [lslf_pkg::POINTS_W-1:0]         points_used
);

  localparam int CW   = CODE_BITS;
  localparam int VW   = lslf_pkg::VALUE_W;
  localparam int RW   = lslf_pkg::RESULT_W;
  localparam int NB   = $clog2(MAX_POINTS + 1);
  localparam int SXW  = CW + NB;
  localparam int SXXW = 2 * CW + NB;
  localparam int SYW  = VW + NB;
  localparam int SXYW = CW + VW + 1 + NB;
  localparam int MW   = SXXW;
  localparam int DW   = SXXW + NB;
  localparam int NUMW = 2 * CW + 2 * NB + VW + 19;
  localparam int MCW  = $clog2(MW);
  localparam int DCW  = $clog2(NUMW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_XY    = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_NEXT  = 4'd5;
  localparam logic [3:0] S_DLOAD = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DEND  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  localparam logic [2:0] P_NSXX  = 3'd0;
  localparam logic [2:0] P_SXSX  = 3'd1;
  localparam logic [2:0] P_SXXSY = 3'd2;
  localparam logic [2:0] P_SXSXY = 3'd3;
  localparam logic [2:0] P_NSXY  = 3'd4;
  localparam logic [2:0] P_SXSY  = 3'd5;

  logic [3:0]               state;
  logic [2:0]               pass;
  logic [CW-1:0]            x_r;
  logic signed [VW-1:0]     y_r;
  lslf_pkg::tag_t           tag_r;
  lslf_pkg::tag_t           tag_in;
  logic [NB-1:0]            n;
  logic [SXW-1:0]           sx;
  logic [SXXW-1:0]          sxx;
  logic signed [SYW-1:0]    sy;
  logic signed [SXYW-1:0]   sxy;
  logic                     ovf;
  logic signed [VW:0]       mul_a;
  logic signed [CW+VW+1:0]  prod;
  logic signed [NUMW-1:0]   a_sel;
  logic [MW-1:0]            b_sel;
  logic                     sub_sel;
  logic signed [NUMW-1:0]   acc;
  logic signed [NUMW-1:0]   a_sh;
  logic [MW-1:0]            b_sh;
  logic                     sub_r;
  logic [MCW-1:0]           mstep;
  logic [DW-1:0]            den;
  logic signed [NUMW-1:0]   num;
  logic                     neg_r;
  logic                     target_r;
  logic [NUMW-1:0]          dq;
  logic [DW-1:0]            rem;
  logic [DCW-1:0]           dstep;
  logic [DW:0]              rem_sh;
  logic                     ge;
  logic [DW:0]              rem_new;
  logic [NUMW-1:0]          lim;
  logic [NUMW-1:0]          mq;
  logic [RW-1:0]            res;
  logic [RW-1:0]            icpt_r;
  logic [RW-1:0]            slp_r;
  logic                     deg_r;
  logic                     take;
  logic                     emit;

  assign tag_in    = lslf_pkg::tag_t'(pop_data[CW+VW+lslf_pkg::TAG_W-1:CW+VW]);
  assign take      = pop_valid && (state == S_IDLE || (state == S_XY && !tag_r.last));
  assign pop_ready = take;
  assign emit      = state == S_EMIT && (!out_valid || out_ready);

  assign mul_a = (state == S_SQ) ? $signed({{(VW + 1 - CW){1'b0}}, x_r})
                                 : {y_r[VW-1], y_r};
  assign prod  = $signed({1'b0, x_r}) * mul_a;

  always_comb begin
    unique case (pass)
      P_NSXX: begin
        a_sel = NUMW'(sxx);
        b_sel = MW'(n);
      end
      P_SXSX: begin
        a_sel = NUMW'(sx);
        b_sel = MW'(sx);
      end
      P_SXXSY: begin
        a_sel = NUMW'(sy);
        b_sel = sxx;
      end
      P_SXSXY: begin
        a_sel = NUMW'(sxy);
        b_sel = MW'(sx);
      end
      P_NSXY: begin
        a_sel = NUMW'(sxy);
        b_sel = MW'(n);
      end
      P_SXSY: begin
        a_sel = NUMW'(sy);
        b_sel = MW'(sx);
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  assign sub_sel = pass == P_SXSX || pass == P_SXSXY || pass == P_SXSY;

  assign rem_sh  = {rem, dq[NUMW-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_new = ge ? rem_sh - {1'b0, den} : rem_sh;

  assign lim = neg_r ? NUMW'(lslf_pkg::SAT_NEG) : NUMW'(lslf_pkg::SAT_POS);
  assign mq  = (dq > lim) ? lim : dq;
  assign res = neg_r ? (~mq[RW-1:0] + 1'b1) : mq[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= P_NSXX;
      tag_r     <= '0;
      n         <= '0;
      sx        <= '0;
      sxx       <= '0;
      sy        <= '0;
      sxy       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (take) begin
        x_r   <= pop_data[CW-1:0];
        y_r   <= pop_data[CW+VW-1:CW];
        tag_r <= tag_in;
      end

      unique case (state)
        S_IDLE, S_XY: begin
          if (state == S_XY) begin
            sy  <= sy + SYW'(y_r);
            sxy <= sxy + SXYW'(prod);
          end
          if (state == S_XY && tag_r.last) begin
            acc   <= '0;
            pass  <= P_NSXX;
            state <= S_LOAD;
          end else if (take) begin
            if (tag_in.incl) begin
              state <= S_SQ;
            end else begin
              ovf <= 1'b1;
              if (tag_in.last) begin
                acc   <= '0;
                pass  <= P_NSXX;
                state <= S_LOAD;
              end else begin
                state <= S_IDLE;
              end
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQ: begin
          sxx   <= sxx + SXXW'(prod[2*CW-1:0]);
          sx    <= sx + SXW'(x_r);
          n     <= n + 1'b1;
          state <= S_XY;
        end
        S_LOAD: begin
          a_sh  <= a_sel;
          b_sh  <= b_sel;
          sub_r <= sub_sel;
          mstep <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (b_sh[0]) begin
            acc <= sub_r ? acc - a_sh : acc + a_sh;
          end
          a_sh  <= a_sh <<< 1;
          b_sh  <= b_sh >> 1;
          mstep <= mstep + 1'b1;
          if (mstep == MCW'(MW - 1)) begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          unique case (pass)
            P_NSXX: begin
              pass  <= P_SXSX;
              state <= S_LOAD;
            end
            P_SXSX: begin
              den   <= acc[DW-1:0];
              deg_r <= acc[DW-1:0] == '0;
              if (acc[DW-1:0] == '0) begin
                icpt_r <= '0;
                slp_r  <= '0;
                state  <= S_EMIT;
              end else begin
                acc   <= '0;
                pass  <= P_SXXSY;
                state <= S_LOAD;
              end
            end
            P_SXXSY: begin
              pass  <= P_SXSXY;
              state <= S_LOAD;
            end
            P_SXSXY: begin
              num      <= acc;
              target_r <= 1'b0;
              state    <= S_DLOAD;
            end
            P_NSXY: begin
              pass  <= P_SXSY;
              state <= S_LOAD;
            end
            P_SXSY: begin
              num      <= acc <<< lslf_pkg::FRAC_SHIFT;
              target_r <= 1'b1;
              state    <= S_DLOAD;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_DLOAD: begin
          neg_r <= num[NUMW-1];
          dq    <= num[NUMW-1] ? (~num + 1'b1) : num;
          rem   <= '0;
          dstep <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem   <= rem_new[DW-1:0];
          dq    <= {dq[NUMW-2:0], ge};
          dstep <= dstep + 1'b1;
          if (dstep == DCW'(NUMW - 1)) begin
            state <= S_DEND;
          end
        end
        S_DEND: begin
          if (target_r) begin
            slp_r <= res;
            state <= S_EMIT;
          end else begin
            icpt_r <= res;
            acc    <= '0;
            pass   <= P_NSXY;
            state  <= S_LOAD;
          end
        end
        S_EMIT: begin
          if (emit) begin
            intercept   <= icpt_r;
            slope       <= slp_r;
            degenerate  <= deg_r;
            overflowed  <= ovf;
            points_used <= lslf_pkg::POINTS_W'(n);
            n           <= '0;
            sx          <= '0;
            sxx         <= '0;
            sy          <= '0;
            sxy         <= '0;
            ovf         <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/least_squares_line_fit_top.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit_top
// Straight-line least-squares fit over a set of calibration points.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one point per transfer, a converter code,
// a Q16.16 true value and a last-point mark. Output channel
// (out_valid/out_ready): one result per set, intercept Q32.16 and slope Q16.32,
// with degenerate, overflow and point count flags.
// A two-entry queue parts the input side from the fit engine, so points are
// taken while the engine works. Each kept point goes twice through the
// shared 13x33 multiplier (x squared, then x times y). Points past MAX_POINTS
// are dropped and flagged.
// After the last point the fit runs six serial multiply passes and two
// restoring divisions; it stops after the first two passes when the
// denominator is zero.
// A stalled receiver holds the result register; the engine then waits with
// its next fit, and the queue fills and drops in_ready.
// Reset clears the count, sums and overflow flag and empties the queue.
// ----------------------------------------------------------------------------
`include "least_squares_line_fit_top_assert.svh"

module least_squares_line_fit_top #(
  parameter int MAX_POINTS = 64,
  parameter int CODE_BITS  = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [CODE_BITS-1:0]                  sample_code,
  input  logic signed [lslf_pkg::VALUE_W-1:0]   true_value,
  input  logic                                  last_point,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lslf_pkg::RESULT_W-1:0]  intercept,
  output logic signed [lslf_pkg::RESULT_W-1:0]  slope,
  output logic                                  degenerate,
  output logic                                  overflowed,
  output logic [lslf_pkg::POINTS_W-1:0]         points_used
);

  localparam int EW = lslf_pkg::TAG_W + lslf_pkg::VALUE_W + CODE_BITS;

  logic          push_valid;
  logic          push_ready;
  logic [EW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [EW-1:0] pop_data;

  lslf_front #(
    .MAX_POINTS (MAX_POINTS),
    .CODE_BITS  (CODE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_code (sample_code),
    .true_value  (true_value),
    .last_point  (last_point),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  lslf_fifo #(
    .W (EW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lslf_back #(
    .MAX_POINTS (MAX_POINTS),
    .CODE_BITS  (CODE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .intercept   (intercept),
    .slope       (slope),
    .degenerate  (degenerate),
    .overflowed  (overflowed),
    .points_used (points_used)
  );

  `LSLF_ASSERT_NEVER(a_deg_zero, out_valid && degenerate && (intercept != 0 || slope != 0), "degenerate fit with nonzero result")
  `LSLF_ASSERT_IMPLIES(a_ovf_full, out_valid && overflowed, points_used == lslf_pkg::POINTS_W'(MAX_POINTS), "overflow flagged below the point limit")
  `LSLF_ASSERT_IMPLIES(a_fit_pts, out_valid && !degenerate, points_used >= 2 || MAX_POINTS > 127, "fit reported from fewer than two points")

endmodule
